@@ rtl/core/stc_pkg.sv @@
// Package for the sequencer transport control: types, codes and constants.
package stc_pkg;

	localparam int unsigned MaxBarsDefault = 8192;
	localparam int unsigned DefaultTpqDefault = 960;
	localparam int unsigned TickW = 40;
	localparam int unsigned BarW = 16;
	localparam int unsigned TpqW = 16;
	localparam int unsigned DeltaW = 32;
	localparam int unsigned CmdW = 3;
	localparam int unsigned ModeW = 2;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CntW = 6;

	typedef enum logic [CmdW-1:0] {
		CMD_PLAY   = 3'd0,
		CMD_STOP   = 3'd1,
		CMD_RECORD = 3'd2,
		CMD_SEEK   = 3'd3,
		CMD_QUERY  = 3'd4
	} cmd_t;

	typedef enum logic [ModeW-1:0] {
		MODE_STOPPED   = 2'd0,
		MODE_PLAYING   = 2'd1,
		MODE_RECORDING = 2'd2
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TPQ        = 2'd0,
		REG_LOOP_START = 2'd1,
		REG_SONG_START = 2'd2,
		REG_SONG_LEN   = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV1,
		ST_SEEK,
		ST_MUL,
		ST_DIV2,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic cmd_load;
		logic div_start;
		logic div_step;
		logic seek_calc;
		logic mul_start;
		logic mul_step;
		logic out_load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_last;
		logic mul_last;
		logic seek_go;
	} dp_stat_t;

endpackage

@@ rtl/core/sequencer_transport_control.sv @@
// Top level of the sequencer transport control.
// Takes one transport request at a time (play, stop, record, seek, query) and returns one
// result with mode, cursor tick and 1-based bar/beat/sixteenth. Before out_valid rises,
// the block runs two serial divisions of the cursor by the bar length (one quotient
// bit per cycle; the first gives the current bar for seek, the second the display
// position of the updated cursor) and then loads the output register. A seek into a
// non-empty song adds a target step and a shift-add multiply between the two divisions.
// The next request is taken the cycle after the result is loaded; a result still
// waiting for out_ready holds the block before that load. Configuration writes go
// straight to registers and should be made while no request is in flight.
module sequencer_transport_control #(
	parameter int unsigned MAX_BARS = stc_pkg::MaxBarsDefault,
	parameter int unsigned DEFAULT_TICKS_PER_QUARTER = stc_pkg::DefaultTpqDefault
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [stc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [stc_pkg::TickW-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [stc_pkg::CmdW-1:0]     cmd,
	input  logic [stc_pkg::DeltaW-1:0]   bar_delta,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [stc_pkg::ModeW-1:0]    transport_mode,
	output logic [stc_pkg::TickW-1:0]    cursor_tick,
	output logic [stc_pkg::BarW-1:0]     display_bar,
	output logic [7:0]                   display_beat,
	output logic [7:0]                   display_sixteenth
);
	import stc_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;

	stc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .ctl
	);

	stc_datapath #(
		.MAX_BARS(MAX_BARS),
		.DEFAULT_TICKS_PER_QUARTER(DEFAULT_TICKS_PER_QUARTER)
	) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cmd, .bar_delta, .ctl, .stat,
		.transport_mode, .cursor_tick, .display_bar, .display_beat, .display_sixteenth
	);

endmodule

@@ rtl/core/stc_datapath.sv @@
// Datapath: transport state, serial divider, shift-add multiplier, display math.
module stc_datapath #(
	parameter int unsigned MAX_BARS = stc_pkg::MaxBarsDefault,
	parameter int unsigned DEFAULT_TICKS_PER_QUARTER = stc_pkg::DefaultTpqDefault
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [stc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [stc_pkg::TickW-1:0]    cfg_data,
	input  logic [stc_pkg::CmdW-1:0]     cmd,
	input  logic [stc_pkg::DeltaW-1:0]   bar_delta,
	input  stc_pkg::dp_cmd_t             ctl,
	output stc_pkg::dp_stat_t            stat,
	output logic [stc_pkg::ModeW-1:0]    transport_mode,
	output logic [stc_pkg::TickW-1:0]    cursor_tick,
	output logic [stc_pkg::BarW-1:0]     display_bar,
	output logic [7:0]                   display_beat,
	output logic [7:0]                   display_sixteenth
);
	import stc_pkg::*;

	localparam logic [TpqW-1:0] DefTpq = TpqW'(DEFAULT_TICKS_PER_QUARTER);
	localparam logic [BarW:0] MaxBars = (BarW+1)'(MAX_BARS);
	localparam int unsigned BlW = TpqW + 2;

	logic [TpqW-1:0]  tpq_q, song_len_q;
	logic [TickW-1:0] loop_start_q, song_start_q;
	mode_t            mode_q;
	logic [1:0]       presses_q;
	logic [TickW-1:0] cursor_q;
	logic [DeltaW-1:0] delta_q;
	logic             is_seek_q;

	// divider: cursor / bar_len, one quotient bit per cycle
	logic [TickW-1:0] quo_q;
	logic [BlW-1:0]   rem_q;
	logic [CntW-1:0]  cnt_q;
	logic [BarW-1:0]  target_q;
	logic [TickW-1:0] prod_q;

	logic [TpqW-1:0] q_eff;
	logic [BlW-1:0]  bar_len;
	logic [BlW:0]    rem_sh;
	logic            rem_ge;
	logic [TickW-1:0] prod_fin;

	assign q_eff   = (tpq_q == '0) ? DefTpq : tpq_q;
	assign bar_len = {q_eff, 2'b00};
	assign rem_sh  = {rem_q, quo_q[TickW-1]};
	assign rem_ge  = rem_sh >= {1'b0, bar_len};
	// product including the current target bit; final value on the last step
	assign prod_fin = prod_q + (target_q[BarW-1] ? TickW'(bar_len) : '0);

	assign stat.div_last = (cnt_q == CntW'(TickW-1));
	assign stat.mul_last = (cnt_q == CntW'(BarW-1));
	assign stat.seek_go  = is_seek_q && (song_len_q != '0);

	// seek target (computed after division)
	logic [BarW:0]   bars, last;
	logic [BarW:0]   cur;
	logic [DeltaW:0] span, room, tgt;
	always_comb begin
		bars = (({1'b0, song_len_q}) > MaxBars) ? MaxBars : {1'b0, song_len_q};
		last = bars - 1'b1;
		cur  = (quo_q > TickW'(last)) ? last : quo_q[BarW:0];
		room = (DeltaW+1)'(last - cur);
		if (delta_q[DeltaW-1]) begin
			span = (DeltaW+1)'(33'h1_0000_0000 - {1'b0, delta_q});
			tgt  = (span > (DeltaW+1)'(cur)) ? '0 : (DeltaW+1)'(cur) - span;
		end else begin
			span = {1'b0, delta_q};
			tgt  = (span > room) ? (DeltaW+1)'(last) : (DeltaW+1)'(cur) + span;
		end
	end

	// display from second division: rem -> beat, sixteenth
	logic [BlW-1:0]  inbar;
	logic [7:0]      beat;
	logic [7:0]      six;
	logic [TpqW-1:0] in_q, sub;
	logic [TpqW+1:0] sub3;
	logic [TpqW+1:0] r4;
	always_comb begin
		inbar = rem_q;
		if (inbar >= {q_eff, 1'b0} + {2'b0, q_eff}) begin
			beat = 8'd4; in_q = TpqW'(inbar - ({q_eff, 1'b0} + {2'b0, q_eff}));
		end else if (inbar >= {1'b0, q_eff, 1'b0}) begin
			beat = 8'd3; in_q = TpqW'(inbar - {1'b0, q_eff, 1'b0});
		end else if (inbar >= {2'b0, q_eff}) begin
			beat = 8'd2; in_q = TpqW'(inbar - {2'b0, q_eff});
		end else begin
			beat = 8'd1; in_q = TpqW'(inbar);
		end
		sub  = q_eff >> 2;
		sub3 = {1'b0, sub, 1'b0} + {2'b0, sub};
		r4   = {2'b0, in_q} - (sub3 + {2'b0, sub});
		// leftover ticks past four sixteenths can reach a 6th or 7th count
		if (sub == '0) six = 8'd1;
		else if ({2'b0, in_q} >= sub3 + {2'b0, sub}) six = 8'd5 +
			8'(r4 >= {2'b0, sub}) + 8'(r4 >= {1'b0, sub, 1'b0});
		else if ({2'b0, in_q} >= sub3) six = 8'd4;
		else if (in_q >= {sub[TpqW-2:0], 1'b0}) six = 8'd3;
		else if (in_q >= sub) six = 8'd2;
		else six = 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpq_q <= '0; song_len_q <= '0; loop_start_q <= '0; song_start_q <= '0;
			mode_q <= MODE_STOPPED; presses_q <= '0; cursor_q <= '0;
			is_seek_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_TPQ:        tpq_q <= cfg_data[TpqW-1:0];
					REG_LOOP_START: loop_start_q <= cfg_data;
					REG_SONG_START: song_start_q <= cfg_data;
					REG_SONG_LEN:   song_len_q <= cfg_data[TpqW-1:0];
					default: ;
				endcase
			end
			if (ctl.cmd_load) begin
				is_seek_q <= (cmd == CMD_SEEK);
				case (cmd)
					CMD_PLAY: if (mode_q == MODE_STOPPED) begin
						mode_q <= MODE_PLAYING; presses_q <= '0;
					end
					CMD_STOP: if (mode_q != MODE_STOPPED) begin
						mode_q <= MODE_STOPPED; presses_q <= 2'd1;
					end else begin
						case (presses_q)
							2'd0: presses_q <= 2'd1;
							2'd1: begin cursor_q <= loop_start_q; presses_q <= 2'd2; end
							default: begin cursor_q <= song_start_q; presses_q <= '0; end
						endcase
					end
					CMD_RECORD: begin
						mode_q <= (mode_q == MODE_RECORDING) ? MODE_PLAYING : MODE_RECORDING;
						presses_q <= '0;
					end
					CMD_SEEK: if (song_len_q == '0) begin
						cursor_q <= '0; presses_q <= '0;
					end
					default: ;
				endcase
			end
			if (ctl.div_start || ctl.mul_start) cnt_q <= '0;
			else if (ctl.div_step || ctl.mul_step) cnt_q <= cnt_q + 1'b1;
			if (ctl.seek_calc) presses_q <= '0;
			if (ctl.mul_step && stat.mul_last) cursor_q <= prod_fin;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.cmd_load) delta_q <= bar_delta;
		if (ctl.div_start) begin
			// after a seek the new cursor is still on its way into cursor_q
			quo_q <= ctl.mul_step ? prod_fin : cursor_q; rem_q <= '0;
		end else if (ctl.div_step) begin
			rem_q <= rem_ge ? BlW'(rem_sh - {1'b0, bar_len}) : rem_sh[BlW-1:0];
			quo_q <= {quo_q[TickW-2:0], rem_ge};
		end
		if (ctl.seek_calc) target_q <= tgt[BarW-1:0];
		// shift-add product, MSB of target first
		if (ctl.mul_start) begin
			prod_q <= '0;
		end else if (ctl.mul_step) begin
			prod_q <= prod_fin << 1;
			target_q <= {target_q[BarW-2:0], 1'b0};
		end
		if (ctl.out_load) begin
			transport_mode    <= mode_q;
			cursor_tick       <= cursor_q;
			display_bar       <= quo_q[BarW-1:0] + 1'b1;
			display_beat      <= beat;
			display_sixteenth <= six;
		end
	end

endmodule

@@ rtl/core/stc_ctrl.sv @@
// Controller state machine for the transport sequencer.
module stc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  stc_pkg::dp_stat_t stat,
	output stc_pkg::dp_cmd_t  ctl
);
	import stc_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DIV1;
			ST_DIV1: if (stat.div_last) state_d = stat.seek_go ? ST_SEEK : ST_DIV2;
			ST_SEEK: state_d = ST_MUL;
			ST_MUL:  if (stat.mul_last) state_d = ST_DIV2;
			ST_DIV2: if (stat.div_last) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.cmd_load = in_valid;
				ctl.div_start = in_valid;
			end
			ST_DIV1: begin
				ctl.div_step = 1'b1;
				ctl.mul_start = stat.div_last && stat.seek_go;
				ctl.div_start = stat.div_last && !stat.seek_go;
			end
			ST_SEEK: ctl.seek_calc = 1'b1;
			ST_MUL: begin
				ctl.mul_step = 1'b1;
				ctl.div_start = stat.mul_last;
			end
			ST_DIV2: ctl.div_step = 1'b1;
			ST_OUT:  ctl.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_one_hot_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.div_step, ctl.mul_step, ctl.seek_calc}))
		else $error("datapath steps overlap");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_DIV1)
		else $error("request not started");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> out_free)
		else $error("result overwritten");

endmodule
